// ===== hw/rtl/tsed_pkg.sv =====
package tsed_pkg;

  localparam logic [31:0] DEFAULT_TRACK_BITS = 32'd200000;

  // Result queue depth between parser and serializer
  localparam int QUEUE_DEPTH = 4;

  // Result kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_FILL    = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  // Element types
  localparam logic [2:0] TYPE_END   = 3'd0;
  localparam logic [2:0] TYPE_SYNC  = 3'd1;
  localparam logic [2:0] TYPE_DATA  = 3'd2;
  localparam logic [2:0] TYPE_GAP   = 3'd3;
  localparam logic [2:0] TYPE_RAW   = 3'd4;
  localparam logic [2:0] TYPE_FUZZY = 3'd5;
  localparam logic [2:0] TYPE_RSVD6 = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_DATA_IN_BITS  = 2'd0;
  localparam logic [1:0] REG_STREAM_LENGTH = 2'd1;
  localparam logic [1:0] REG_TRACK_BITS    = 2'd2;

  // Parser phases
  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_SIZE    = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DONE    = 4'b1000
  } phase_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] byte_address;
    logic [7:0]  data_byte;
    logic [29:0] fill_end;
    logic [61:0] final_length;
    logic        last;
  } result_t;

  // Results caused by one byte: up to two
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } pair_t;

endpackage

// ===== hw/rtl/tsed_front.sv =====
// Byte parser: consumes one byte per cycle on take and produces up to two results.
module tsed_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          stream_byte,
  input  logic                data_in_bits,
  input  logic [31:0]         stream_length,
  input  logic [31:0]         track_len,
  output tsed_pkg::pair_t     pair
);

  logic [31:0]  stream_position;
  tsed_pkg::phase_t phase;
  logic [2:0]   element_type;
  logic [2:0]   size_bytes_left;
  logic [55:0]  size_accumulator;
  logic [63:0]  bit_position;
  logic [55:0]  payload_bytes_left;
  logic [31:0]  write_address;
  logic         copy_enabled;

  // Buffer size in bytes: track bits (default if zero) rounded up to bytes
  logic [29:0]  buf_size;
  always_comb begin
    if (track_len == 32'd0) begin
      buf_size = 30'((tsed_pkg::DEFAULT_TRACK_BITS + 32'd7) >> 3);
    end else begin
      buf_size = 30'(({1'b0, track_len} + 33'd7) >> 3);
    end
  end

  // Next-state and result logic
  logic [31:0]  sp_next;
  tsed_pkg::phase_t ph_next;
  logic [2:0]   et_next;
  logic [2:0]   sbl_next;
  logic [55:0]  acc_next;
  logic [63:0]  bp_next;
  logic [55:0]  pbl_next;
  logic [31:0]  wa_next;
  logic         ce_next;
  logic         clear;
  tsed_pkg::pair_t pr;

  logic [31:0]  left;
  logic [2:0]   hdr_type;
  logic [2:0]   hdr_width;
  logic [55:0]  sz;
  logic [55:0]  elem_type_sz;
  logic         run_elem;
  logic [2:0]   run_type;
  logic [63:0]  ebits;
  logic [55:0]  nbytes;
  logic [60:0]  bpos;
  logic [61:0]  fill_stop;
  logic [61:0]  fill_clip;
  logic [61:0]  flen;
  logic         hit0;

  always_comb begin
    sp_next  = stream_position;
    ph_next  = phase;
    et_next  = element_type;
    sbl_next = size_bytes_left;
    acc_next = size_accumulator;
    bp_next  = bit_position;
    pbl_next = payload_bytes_left;
    wa_next  = write_address;
    ce_next  = copy_enabled;
    clear    = 1'b0;
    pr       = '0;
    run_elem = 1'b0;
    run_type = element_type;
    sz       = '0;
    hit0     = 1'b0;
    ebits     = '0;
    nbytes    = '0;
    fill_stop = '0;
    fill_clip = '0;
    hdr_type  = stream_byte[2:0];
    hdr_width = stream_byte[7:5];
    left     = stream_length - stream_position - 32'd1;
    elem_type_sz = ((size_accumulator << 8) | {48'd0, stream_byte});
    flen     = {1'b0, bit_position[63:3]} + {61'd0, (bit_position[2:0] != 3'd0)};
    bpos     = bit_position[63:3];

    if (stream_position >= stream_length) begin
      clear = 1'b1;
    end else begin
      sp_next = stream_position + 32'd1;
      unique case (phase)
        tsed_pkg::PH_HEADER: begin
          if (hdr_type == tsed_pkg::TYPE_END && hdr_width == 3'd0) begin
            pr.v0 = 1'b1;
            pr.r0.kind = tsed_pkg::KIND_FINISH;
            pr.r0.final_length = flen;
            ph_next = tsed_pkg::PH_DONE;
          end else if ({29'd0, hdr_width} > left) begin
            pr.v0 = 1'b1;
            pr.r0.kind = tsed_pkg::KIND_CORRUPT;
            ph_next = tsed_pkg::PH_DONE;
          end else begin
            et_next  = hdr_type;
            acc_next = '0;
            sbl_next = hdr_width;
            if (hdr_width == 3'd0) begin
              run_elem = 1'b1;
              run_type = hdr_type;
              sz = '0;
            end else begin
              ph_next = tsed_pkg::PH_SIZE;
            end
          end
        end
        tsed_pkg::PH_SIZE: begin
          acc_next = elem_type_sz;
          sbl_next = size_bytes_left - 3'd1;
          if (sbl_next == 3'd0) begin
            run_elem = 1'b1;
            sz = elem_type_sz;
          end
        end
        tsed_pkg::PH_PAYLOAD: begin
          if (copy_enabled) begin
            pr.v0 = 1'b1;
            pr.r0.kind = tsed_pkg::KIND_WRITE;
            pr.r0.byte_address = write_address[28:0];
            pr.r0.data_byte = stream_byte;
            wa_next = write_address + 32'd1;
          end
          pbl_next = payload_bytes_left - 56'd1;
          if (pbl_next == 56'd0) ph_next = tsed_pkg::PH_HEADER;
        end
        tsed_pkg::PH_DONE: begin
          hit0 = 1'b1;
        end
        default: ;
      endcase

      // Element action once header and size are complete
      ebits  = data_in_bits ? {8'd0, sz} : {5'd0, sz, 3'd0};
      nbytes = data_in_bits ? 56'(({1'b0, sz} + 57'd7) >> 3) : sz;
      fill_stop = {1'b0, bpos} +
        62'(({61'd0, bit_position[2:0]} + {1'b0, ebits} + 65'd7) >> 3);
      fill_clip = (fill_stop > {32'd0, buf_size}) ? {32'd0, buf_size} : fill_stop;
      if (run_elem) begin
        ph_next = tsed_pkg::PH_HEADER;
        if (run_type == tsed_pkg::TYPE_SYNC || run_type == tsed_pkg::TYPE_DATA ||
            run_type == tsed_pkg::TYPE_RAW) begin
          if ({8'd0, nbytes} <= {32'd0, left}) begin
            ce_next = ({3'd0, bpos} + {8'd0, nbytes}) <= {34'd0, buf_size};
            wa_next = ce_next ? bpos[31:0] : 32'd0;
            bp_next = bit_position + ebits;
            if (nbytes != 56'd0) begin
              pbl_next = nbytes;
              ph_next = tsed_pkg::PH_PAYLOAD;
            end
          end
        end else if (run_type == tsed_pkg::TYPE_GAP) begin
          bp_next = bit_position + ebits;
        end else if (run_type == tsed_pkg::TYPE_FUZZY) begin
          if ({1'b0, bpos} < fill_clip) begin
            pr.v0 = 1'b1;
            pr.r0.kind = tsed_pkg::KIND_FILL;
            pr.r0.byte_address = bpos[28:0];
            pr.r0.fill_end = fill_clip[29:0];
          end
          bp_next = bit_position + ebits;
        end
      end

      // Stream end
      if (left == 32'd0) begin
        if (!hit0 && ph_next != tsed_pkg::PH_DONE) begin
          if (pr.v0) begin
            pr.v1 = 1'b1;
            pr.r1.kind = tsed_pkg::KIND_FINISH;
            pr.r1.final_length = {1'b0, bp_next[63:3]} +
              {61'd0, (bp_next[2:0] != 3'd0)};
          end else begin
            pr.v0 = 1'b1;
            pr.r0.kind = tsed_pkg::KIND_FINISH;
            pr.r0.final_length = {1'b0, bp_next[63:3]} +
              {61'd0, (bp_next[2:0] != 3'd0)};
          end
        end
        clear = 1'b1;
      end
      if (pr.v1) pr.r1.last = 1'b1;
      else if (pr.v0) pr.r0.last = 1'b1;
    end
  end

  assign pair = pr;

  // State registers
  always_ff @(posedge clk) begin
    if (rst || (take && clear)) begin
      stream_position    <= '0;
      phase              <= tsed_pkg::PH_HEADER;
      element_type       <= '0;
      size_bytes_left    <= '0;
      size_accumulator   <= '0;
      bit_position       <= '0;
      payload_bytes_left <= '0;
      write_address      <= '0;
      copy_enabled       <= 1'b0;
    end else if (take) begin
      stream_position    <= sp_next;
      phase              <= ph_next;
      element_type       <= et_next;
      size_bytes_left    <= sbl_next;
      size_accumulator   <= acc_next;
      bit_position       <= bp_next;
      payload_bytes_left <= pbl_next;
      write_address      <= wa_next;
      copy_enabled       <= ce_next;
    end
  end

endmodule

// ===== hw/rtl/tsed_queue.sv =====
// Short queue of result pairs between parser and output serializer.
module tsed_queue #(
  parameter int DEPTH = tsed_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tsed_pkg::pair_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output tsed_pkg::pair_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tsed_pkg::pair_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers wrap at DEPTH
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== hw/rtl/tsed_back.sv =====
// Serializer: hands out the one or two results of each queued pair.
module tsed_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  tsed_pkg::pair_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output tsed_pkg::result_t res
);

  logic second;

  assign out_valid = !empty && (second ? head.v1 : head.v0);
  assign res = second ? head.r1 : head.r0;
  assign pop = !empty && out_ready && (second || !head.v1);

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (out_valid && out_ready) begin
      second <= !second && head.v1;
    end
  end

endmodule

// ===== hw/rtl/track_stream_element_decoder_top.sv =====
// Track stream element decoder.
// Each accepted byte's results are registered in the result queue.
// Throughput: 1 byte per cycle while the result queue is not full; a byte
// with two results hands them out in turn from a result queue (default depth 4).
// Reset (rst, synchronous): parser state, config registers and queue cleared.
module track_stream_element_decoder_top #(
  parameter int QUEUE_DEPTH = tsed_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [28:0] byte_address,
  output logic [7:0]  data_byte,
  output logic [29:0] fill_end,
  output logic [61:0] final_length,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic        data_in_bits;
  logic [31:0] stream_length;
  logic [31:0] track_len;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      data_in_bits  <= 1'b0;
      stream_length <= '0;
      track_len     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsed_pkg::REG_DATA_IN_BITS:  data_in_bits  <= cfg_data[0];
        tsed_pkg::REG_STREAM_LENGTH: stream_length <= cfg_data;
        tsed_pkg::REG_TRACK_BITS:    track_len     <= cfg_data;
        default: ;
      endcase
    end
  end

  tsed_pkg::pair_t   pair;
  tsed_pkg::pair_t   head;
  tsed_pkg::result_t res;
  logic full, empty, pop, take;

  assign in_ready = !full;
  assign take = in_valid && in_ready;

  tsed_front u_front (
    .clk, .rst, .take, .stream_byte, .data_in_bits, .stream_length,
    .track_len, .pair
  );

  tsed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst,
    .push(take && pair.v0), .push_data(pair), .full,
    .pop, .empty, .head
  );

  tsed_back u_back (
    .clk, .rst, .empty, .head, .pop, .out_valid, .out_ready, .res
  );

  assign kind         = res.kind;
  assign byte_address = res.byte_address;
  assign data_byte    = res.data_byte;
  assign fill_end     = res.fill_end;
  assign final_length = res.final_length;
  assign last         = res.last;

endmodule

// ===== hw/rtl/tsed_checker.sv =====
// Port-level checks on the decoder.
module tsed_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] data_byte,
  input logic [29:0] fill_end,
  input logic [61:0] final_length,
  input logic       last
);

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(last))
    else $error("result changed while stalled");

  // Finish and corrupt always close a byte's results
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == tsed_pkg::KIND_FINISH || kind == tsed_pkg::KIND_CORRUPT)
      |-> last)
    else $error("terminal result not last");

  // Fields unused by corrupt and non-write results read zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == tsed_pkg::KIND_CORRUPT |-> final_length == '0 && fill_end == '0)
    else $error("corrupt carries data");

  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != tsed_pkg::KIND_WRITE |-> data_byte == '0)
    else $error("data byte on non-write");

endmodule

bind track_stream_element_decoder_top tsed_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .kind, .data_byte, .fill_end,
  .final_length, .last
);

// ===== test/track_stream_element_decoder_checker.sv =====
`timescale 1ns / 1ps

module track_stream_element_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  kind,
  input  logic [28:0] byte_address,
  input  logic [7:0]  data_byte,
  input  logic [29:0] fill_end,
  input  logic [61:0] final_length,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam logic [63:0] MASK56 = 64'h00FF_FFFF_FFFF_FFFF;

  // Decoder phases
  typedef enum logic [1:0] {
    P_HEADER  = 2'd0,
    P_SIZE    = 2'd1,
    P_PAYLOAD = 2'd2,
    P_DONE    = 2'd3
  } dec_phase_t;

  // Shadow registers and parser state
  logic        m_in_bits;
  logic [31:0] m_stream_len;
  logic [31:0] m_track_len;
  logic [31:0] m_pos;
  dec_phase_t  m_phase;
  logic [2:0]  m_type;
  logic [2:0]  m_size_left;
  logic [63:0] m_size_acc;
  logic [63:0] m_bitpos;
  logic [63:0] m_payload_left;
  logic [31:0] m_waddr;
  logic        m_copy;

  tsed_pkg::result_t expected_q[$];
  tsed_pkg::result_t step_res[$];

  function automatic tsed_pkg::result_t mk(logic [1:0] k, logic [63:0] a, logic [7:0] d,
                                           logic [63:0] fe, logic [63:0] fl);
    tsed_pkg::result_t r;
    r.kind = k;
    r.byte_address = a[28:0];
    r.data_byte = d;
    r.fill_end = fe[29:0];
    r.final_length = fl[61:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic [63:0] buffer_bytes();
    logic [63:0] b;
    b = (m_track_len != 0) ? {32'd0, m_track_len} :
                             {32'd0, tsed_pkg::DEFAULT_TRACK_BITS};
    return (b + 64'd7) >> 3;
  endfunction

  function automatic logic [63:0] stream_bytes_out();
    return (m_bitpos >> 3) + ((m_bitpos[2:0] != 0) ? 64'd1 : 64'd0);
  endfunction

  task automatic clear_parser();
    m_pos = 0; m_phase = P_HEADER; m_type = 0; m_size_left = 0;
    m_size_acc = 0; m_bitpos = 0; m_payload_left = 0; m_waddr = 0; m_copy = 0;
  endtask

  // Element with complete header and size
  task automatic run_element(logic [63:0] left);
    logic [63:0] s, bits, nbytes, bsz, bp, st, en;
    s = m_size_acc & MASK56;
    bits = m_in_bits ? s : (s << 3);
    nbytes = m_in_bits ? ((s + 64'd7) >> 3) : s;
    bsz = buffer_bytes();
    m_phase = P_HEADER;
    case (m_type)
      tsed_pkg::TYPE_SYNC, tsed_pkg::TYPE_DATA, tsed_pkg::TYPE_RAW: begin
        if (nbytes <= left) begin
          bp = m_bitpos >> 3;
          m_copy = (bp + nbytes <= bsz);
          m_waddr = m_copy ? bp[31:0] : 32'd0;
          m_bitpos = m_bitpos + bits;
          if (nbytes != 0) begin
            m_payload_left = nbytes;
            m_phase = P_PAYLOAD;
          end
        end
      end
      tsed_pkg::TYPE_GAP: m_bitpos = m_bitpos + bits;
      tsed_pkg::TYPE_FUZZY: begin
        st = m_bitpos >> 3;
        en = st + (({61'd0, m_bitpos[2:0]} + bits + 64'd7) >> 3);
        if (en > bsz) en = bsz;
        if (st < en) step_res.push_back(mk(tsed_pkg::KIND_FILL, st, 8'd0, en, 64'd0));
        m_bitpos = m_bitpos + bits;
      end
      default: ;
    endcase
  endtask

  task automatic decode_byte(logic [7:0] b);
    logic [63:0] left;
    logic [2:0]  w;
    logic        was_done;
    tsed_pkg::result_t r;
    step_res.delete();
    if ({32'd0, m_pos} >= {32'd0, m_stream_len}) begin
      clear_parser();
      return;
    end
    left = {32'd0, m_stream_len} - {32'd0, m_pos} - 64'd1;
    m_pos = m_pos + 1;
    was_done = 0;
    case (m_phase)
      P_HEADER: begin
        w = b[7:5];
        if (b[2:0] == tsed_pkg::TYPE_END && w == 0) begin
          step_res.push_back(mk(tsed_pkg::KIND_FINISH, 0, 0, 0, stream_bytes_out()));
          m_phase = P_DONE;
        end else if ({61'd0, w} > left) begin
          step_res.push_back(mk(tsed_pkg::KIND_CORRUPT, 0, 0, 0, 0));
          m_phase = P_DONE;
        end else begin
          m_type = b[2:0];
          m_size_acc = 0;
          m_size_left = w;
          if (w == 0) run_element(left);
          else m_phase = P_SIZE;
        end
      end
      P_SIZE: begin
        m_size_acc = ((m_size_acc << 8) | {56'd0, b}) & MASK56;
        m_size_left = m_size_left - 3'd1;
        if (m_size_left == 0) run_element(left);
      end
      P_PAYLOAD: begin
        if (m_copy) begin
          step_res.push_back(mk(tsed_pkg::KIND_WRITE, {32'd0, m_waddr}, b, 0, 0));
          m_waddr = m_waddr + 1;
        end
        m_payload_left = (m_payload_left - 64'd1) & MASK56;
        if (m_payload_left == 0) m_phase = P_HEADER;
      end
      default: was_done = 1;
    endcase
    if (left == 0) begin
      if (!was_done && m_phase != P_DONE)
        step_res.push_back(mk(tsed_pkg::KIND_FINISH, 0, 0, 0, stream_bytes_out()));
      clear_parser();
    end
    foreach (step_res[i]) begin
      r = step_res[i];
      r.last = (i == step_res.size() - 1);
      expected_q.push_back(r);
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  assign pending = expected_q.size();

  initial begin
    errors = 0;
    m_in_bits = 0; m_stream_len = 0; m_track_len = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    tsed_pkg::result_t e;
    if (rst) begin
      m_in_bits = 0; m_stream_len = 0; m_track_len = 0;
      clear_parser();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsed_pkg::REG_DATA_IN_BITS:  m_in_bits = cfg_data[0];
          tsed_pkg::REG_STREAM_LENGTH: m_stream_len = cfg_data;
          tsed_pkg::REG_TRACK_BITS:    m_track_len = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected item kind", {62'd0, kind}, 0);
        end else begin
          e = expected_q.pop_front();
          if (kind != e.kind) report("kind", kind, e.kind);
          if (byte_address != e.byte_address)
            report("byte_address", byte_address, e.byte_address);
          if (data_byte != e.data_byte) report("data_byte", data_byte, e.data_byte);
          if (fill_end != e.fill_end) report("fill_end", fill_end, e.fill_end);
          if (final_length != e.final_length)
            report("final_length", final_length, e.final_length);
          if (last != e.last) report("last", last, e.last);
        end
      end
      if (in_valid && in_ready) decode_byte(stream_byte);
    end
  end

endmodule

// ===== test/tb_track_stream_element_decoder_top.sv =====
`timescale 1ns / 1ps

module tb_track_stream_element_decoder_top;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  stream_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  kind;
  logic [28:0] byte_address;
  logic [7:0]  data_byte;
  logic [29:0] fill_end;
  logic [61:0] final_length;
  logic        last;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  int          errors;
  int          pending;
  bit          hold_off = 0;
  bit          quiet = 0;
  bit          sending = 1;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  track_stream_element_decoder_top uut (.*);

  track_stream_element_decoder_checker chk (.*);

  // Receiver: random stalls, quiet stretches, and one long hold-off
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 0;
    else if (quiet) out_ready <= 1;
    else out_ready <= ($urandom_range(99) >= 31);
  end

  initial begin
    #300000;
    repeat (1) @(negedge clk);
    while (sending) @(negedge clk);
    hold_off = 1;
    repeat (200) @(negedge clk);
    hold_off = 0;
  end

  // One register write, then the channel back to idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  // Valid stays up between back-to-back items; drain() drops it
  task automatic send_byte(logic [7:0] b);
    if (!quiet)
      while ($urandom_range(99) < 31) begin
        in_valid <= 0;
        @(negedge clk);
      end
    in_valid <= 1; stream_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic send_element(logic [2:0] t, int w, logic [55:0] size, int pay);
    send_byte({w[2:0], 2'($urandom), t});
    for (int i = w - 1; i >= 0; i--) send_byte(size[i*8 +: 8]);
    for (int i = 0; i < pay; i++) send_byte(8'($urandom));
  endtask

  // One stream of random well-formed elements with occasional noise
  task automatic random_stream(int len, output int sent);
    int sz, w, nb;
    logic [2:0] t;
    sent = 0;
    while (sent < len) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom)); sent++;
      end else begin
        t = 3'($urandom_range(7));
        if (t == tsed_pkg::TYPE_END && $urandom_range(3) != 0) t = tsed_pkg::TYPE_DATA;
        sz = $urandom_range(6);
        w = (sz > 255) ? 2 : 1;
        if ($urandom_range(7) == 0) w = $urandom_range(7);
        nb = (t == tsed_pkg::TYPE_SYNC || t == tsed_pkg::TYPE_DATA ||
              t == tsed_pkg::TYPE_RAW) ? sz : 0;
        send_element(t, w, 56'(sz), (w == 0) ? 0 : nb);
        sent += 1 + w + ((w == 0) ? 0 : nb);
      end
    end
  endtask

  initial begin
    int cnt, len, sent;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: byte sizes, small buffer
    write_reg(tsed_pkg::REG_DATA_IN_BITS, 32'd0);
    write_reg(tsed_pkg::REG_TRACK_BITS, 32'd40);
    write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'd22);
    send_element(tsed_pkg::TYPE_DATA, 1, 56'd3, 3);
    send_element(tsed_pkg::TYPE_GAP, 1, 56'd1, 0);
    send_element(tsed_pkg::TYPE_FUZZY, 1, 56'd2, 0);
    send_element(tsed_pkg::TYPE_SYNC, 1, 56'd2, 2);
    send_element(tsed_pkg::TYPE_RSVD6, 1, 56'd0, 0);
    send_element(tsed_pkg::TYPE_RAW, 1, 56'd9, 0);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);
    drain();

    // Directed: bit sizes, default buffer, finish then swallow
    write_reg(tsed_pkg::REG_DATA_IN_BITS, 32'd1);
    write_reg(tsed_pkg::REG_TRACK_BITS, 32'd0);
    write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'd8);
    send_element(tsed_pkg::TYPE_FUZZY, 1, 56'd13, 0);
    send_element(tsed_pkg::TYPE_DATA, 1, 56'd9, 2);
    send_byte(8'h00);
    send_byte(8'hE7);
    drain();
    // Corrupt width, and extreme track length
    write_reg(tsed_pkg::REG_TRACK_BITS, 32'hFFFF_FFFF);
    write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'd3);
    send_byte(8'hE1); send_byte(8'h00); send_byte(8'h00);
    drain();
    // Byte past length after shortening
    write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'hFFFF_FFFF);
    send_byte(8'h03);
    drain();
    repeat (10) @(negedge clk);
    write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'd0);
    send_byte(8'h55);
    drain();

    // Random streams
    cnt = 0;
    while (cnt < 1550) begin
      if ($urandom_range(15) == 0) quiet = 1; else quiet = 0;
      write_reg(tsed_pkg::REG_DATA_IN_BITS, 32'($urandom_range(1)));
      case ($urandom_range(3))
        0: write_reg(tsed_pkg::REG_TRACK_BITS, 32'($urandom_range(8, 80)));
        1: write_reg(tsed_pkg::REG_TRACK_BITS, 32'd0);
        2: write_reg(tsed_pkg::REG_TRACK_BITS, 32'hFFFF_FFFF);
        default: write_reg(tsed_pkg::REG_TRACK_BITS, $urandom);
      endcase
      len = $urandom_range(1, 60);
      write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'(len));
      random_stream(len, sent);
      cnt += sent;
      drain();
    end
    quiet = 0;
    sending = 0;

    // Pressure: long hold-off while bytes keep coming
    wait (hold_off);
    @(negedge clk);
    write_reg(tsed_pkg::REG_DATA_IN_BITS, 32'd0);
    write_reg(tsed_pkg::REG_TRACK_BITS, 32'd0);
    write_reg(tsed_pkg::REG_STREAM_LENGTH, 32'd40);
    send_element(tsed_pkg::TYPE_DATA, 1, 56'd38, 38);
    in_valid <= 0;
    wait (!hold_off);
    drain();
    repeat (20) @(negedge clk);

    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
